// ----- hdl/drive_letter_allocator_table_defines.svh -----
// Assertion macros shared by the drive letter allocator RTL.
`ifndef DRIVE_LETTER_ALLOCATOR_TABLE_DEFINES_SVH
`define DRIVE_LETTER_ALLOCATOR_TABLE_DEFINES_SVH

// Same-cycle implication, checked on clk, muted during rst
`define DLA_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on clk, muted during rst
`define DLA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/dla_pkg.sv -----
// Shared types and constants for the drive letter allocator.
`timescale 1ns / 1ps

package dla_pkg;

  // Letter table size and index widths
  localparam int DLA_ENTRIES     = 26;
  localparam int DLA_IDX_W       = 5;
  localparam int DLA_CNT_W       = 5;
  localparam int DLA_HANDLE_BITS = 32;

  // Item field widths
  localparam int DLA_FUNC_W   = 2;
  localparam int DLA_CODE_W   = 8;
  localparam int DLA_LETTER_W = 7;

  // Character codes of the first and last letter
  localparam logic [DLA_CODE_W-1:0] DLA_CODE_A = 8'd65;
  localparam logic [DLA_CODE_W-1:0] DLA_CODE_Z = 8'd90;

  // Operation codes
  typedef enum logic [DLA_FUNC_W-1:0] {
    OP_MOUNT   = 2'd0,
    OP_UNMOUNT = 2'd1,
    OP_LOOKUP  = 2'd2
  } dla_op_t;

  // Request to the free stack
  typedef struct packed {
    logic                 pop;
    logic                 push;
    logic [DLA_IDX_W-1:0] push_idx;
  } dla_stack_req_t;

  // Status from the free stack
  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [DLA_IDX_W-1:0] top_idx;
    logic [DLA_CNT_W-1:0] count;
  } dla_stack_stat_t;

endpackage

// ----- hdl/dla_free_stack.sv -----
// LIFO stack of free letter indices, full with letter A on top after reset.
`timescale 1ns / 1ps

module dla_free_stack
  import dla_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  dla_stack_req_t  req,
  output dla_stack_stat_t stat
);

  logic [DLA_IDX_W-1:0] slots [DLA_ENTRIES];
  logic [DLA_CNT_W-1:0] count;
  logic [DLA_CNT_W-1:0] count_m1;

  assign count_m1 = count - 1'b1;

  // Status seen by the request logic
  always_comb begin
    stat.empty   = (count == '0);
    stat.full    = (count == DLA_CNT_W'(DLA_ENTRIES));
    stat.count   = count;
    stat.top_idx = stat.empty ? '0 : slots[count_m1[DLA_IDX_W-1:0]];
  end

  // Slot array and fill count; pop and push never come together
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLA_ENTRIES; i++) begin
        slots[i] <= DLA_IDX_W'(DLA_ENTRIES - 1 - i);
      end
      count <= DLA_CNT_W'(DLA_ENTRIES);
    end else if (req.pop && !stat.empty) begin
      count <= count_m1;
    end else if (req.push && !stat.full) begin
      slots[count[DLA_IDX_W-1:0]] <= req.push_idx;
      count                       <= count + 1'b1;
    end
  end

endmodule

// ----- hdl/drive_letter_allocator_table.sv -----
// Top level of the drive letter allocator: free stack plus handle table.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+---------------------------------------------
//  s_axis  | in  | s_tvalid/tready  | s_tdata: func, letter_code, handle_in
//  m_axis  | out | m_tvalid/tready  | m_tdata: letter_out, handle_out, ok
//
//  One item per cycle sustained while m_tready stays high; an item passes the
//  input register, then the table and stack update together with the result register.
//  rst is synchronous: the stack refills with A on top, all handles clear.
//  A stalled result holds; the input register still drains into the result
//  register in the cycle the result is taken, so no bubble is added.
`timescale 1ns / 1ps

`include "drive_letter_allocator_table_defines.svh"

module drive_letter_allocator_table
  import dla_pkg::*;
#(
  parameter  int HANDLE_BITS = DLA_HANDLE_BITS,
  localparam int IN_FLD_W    = DLA_FUNC_W + DLA_CODE_W + HANDLE_BITS,
  localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8,
  localparam int OUT_FLD_W   = DLA_LETTER_W + HANDLE_BITS + 1,
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // func, letter_code, handle_in (low bit first), zero padded
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // letter_out, handle_out, ok (low bit first), zero padded
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Input register
  logic                    in_vld;
  logic [DLA_FUNC_W-1:0]   in_func;
  logic [DLA_CODE_W-1:0]   in_code;
  logic [HANDLE_BITS-1:0]  in_handle;

  // Result register
  logic                    res_vld;
  logic [DLA_LETTER_W-1:0] res_letter;
  logic [HANDLE_BITS-1:0]  res_handle;
  logic                    res_ok;

  // Handle table, zero means empty
  logic [HANDLE_BITS-1:0]  handles [DLA_ENTRIES];

  logic                    advance;
  logic                    fire;
  logic                    code_ok;
  logic [DLA_CODE_W-1:0]   code_off;
  logic [DLA_IDX_W-1:0]    cidx;
  logic [HANDLE_BITS-1:0]  entry;

  logic                    wr_en;
  logic [DLA_IDX_W-1:0]    wr_idx;
  logic [HANDLE_BITS-1:0]  wr_data;
  logic [DLA_LETTER_W-1:0] letter_next;
  logic [HANDLE_BITS-1:0]  handle_next;
  logic                    ok_next;

  dla_stack_req_t          st_req;
  dla_stack_stat_t         st_stat;

  // Flow control
  assign advance  = !res_vld || m_tready;
  assign fire     = in_vld && advance;
  assign s_tready = !in_vld || advance;
  assign m_tvalid = res_vld;

  // Output packing
  always_comb begin
    m_tdata = '0;
    m_tdata[DLA_LETTER_W-1:0]                        = res_letter;
    m_tdata[DLA_LETTER_W +: HANDLE_BITS]             = res_handle;
    m_tdata[DLA_LETTER_W + HANDLE_BITS]              = res_ok;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func   <= s_tdata[DLA_FUNC_W-1:0];
      in_code   <= s_tdata[DLA_FUNC_W +: DLA_CODE_W];
      in_handle <= s_tdata[DLA_FUNC_W + DLA_CODE_W +: HANDLE_BITS];
    end
  end

  // Letter decode and table read
  assign code_ok  = (in_code >= DLA_CODE_A) && (in_code <= DLA_CODE_Z);
  assign code_off = in_code - DLA_CODE_A;
  assign cidx     = code_off[DLA_IDX_W-1:0];
  assign entry    = code_ok ? handles[cidx] : '0;

  // Operation decode
  always_comb begin
    st_req      = '0;
    wr_en       = 1'b0;
    wr_idx      = cidx;
    wr_data     = '0;
    letter_next = '0;
    handle_next = '0;
    ok_next     = 1'b0;
    unique case (in_func)
      OP_MOUNT: begin
        if (!st_stat.empty) begin
          st_req.pop = fire;
          if (st_stat.top_idx < DLA_IDX_W'(DLA_ENTRIES)) begin
            wr_en       = fire;
            wr_idx      = st_stat.top_idx;
            wr_data     = in_handle;
            letter_next = DLA_CODE_A[DLA_LETTER_W-1:0]
                          + DLA_LETTER_W'(st_stat.top_idx);
            ok_next     = 1'b1;
          end
        end
      end
      OP_UNMOUNT: begin
        if (code_ok && entry != '0) begin
          wr_en           = fire;
          st_req.push     = fire;
          st_req.push_idx = cidx;
          ok_next         = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (code_ok) begin
          handle_next = entry;
          ok_next     = 1'b1;
        end
      end
      default: begin
        // unused operation code: all result fields zero
      end
    endcase
  end

  // Handle table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLA_ENTRIES; i++) begin
        handles[i] <= '0;
      end
    end else if (wr_en) begin
      handles[wr_idx] <= wr_data;
    end
  end

  dla_free_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .req  (st_req),
    .stat (st_stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_letter <= letter_next;
      res_handle <= handle_next;
      res_ok     <= ok_next;
    end
  end

  // Checks
  `DLA_ASSERT_NOW(a_letter_needs_ok, res_vld && res_letter != '0, res_ok,
                  "granted letter without ok")
  `DLA_ASSERT_NOW(a_handle_needs_ok, res_vld && res_handle != '0, res_ok,
                  "handle returned without ok")
  `DLA_ASSERT_NOW(a_count_bound, 1'b1, st_stat.count <= DLA_CNT_W'(DLA_ENTRIES),
                  "free stack count above table size")
  `DLA_ASSERT_NEXT(a_empty_mount_holds, fire && in_func == OP_MOUNT && st_stat.empty,
                   $stable(st_stat.count), "mount on empty stack changed the stack")
  `DLA_ASSERT_NEXT(a_unmount_clears, fire && in_func == OP_UNMOUNT && ok_next,
                   handles[$past(cidx)] == '0, "unmount left the entry set")

endmodule

// ----- tb/drive_letter_allocator_table_test.sv -----
// Self-checking testbench for the drive letter allocator stream block.
`timescale 1ns / 1ps

module drive_letter_allocator_table_test
  import dla_pkg::*;
();

  // Packed widths of the stream payloads, padded to whole bytes
  localparam int IN_W  = ((DLA_FUNC_W + DLA_CODE_W + DLA_HANDLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((DLA_LETTER_W + DLA_HANDLE_BITS + 1 + 7) / 8) * 8;

  // Operation code the block ignores
  localparam logic [DLA_FUNC_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 830;
  localparam int IDLE_LIMIT    = 4000;
  localparam int STALL_CYCLES  = 150;
  localparam int STALL_AT_ITEM = 400;
  localparam int DRAIN_CYCLES  = 8;

  // One answer from the block
  typedef struct packed {
    logic [DLA_LETTER_W-1:0]    letter;
    logic [DLA_HANDLE_BITS-1:0] handle;
    logic                       ok;
  } answer_t;

  // Tracks the free stack and handle table, and checks answers in order
  class alloc_scoreboard;
    logic [DLA_IDX_W-1:0]       free_stack [DLA_ENTRIES];
    int unsigned                free_count;
    logic [DLA_HANDLE_BITS-1:0] handle_table [DLA_ENTRIES];
    answer_t                    expected_answers [$];
    int unsigned mismatches, accepted, checked;
    int unsigned n_granted, n_exhausted, n_released, n_refused, n_lookups, n_ignored;

    function new();
      for (int i = 0; i < DLA_ENTRIES; i++) begin
        free_stack[i]   = DLA_IDX_W'(DLA_ENTRIES - 1 - i);
        handle_table[i] = '0;
      end
      free_count = DLA_ENTRIES;
    endfunction

    // Work out the answer to an accepted request and update the tables
    function void note_request(logic [DLA_FUNC_W-1:0] func, logic [DLA_CODE_W-1:0] code,
                               logic [DLA_HANDLE_BITS-1:0] handle);
      answer_t              ans;
      logic [DLA_IDX_W-1:0] idx;
      logic                 in_range;
      ans      = '0;
      in_range = (code >= DLA_CODE_A) && (code <= DLA_CODE_Z);
      idx      = DLA_IDX_W'(code - DLA_CODE_A);
      accepted++;
      case (func)
        OP_MOUNT: begin
          if (free_count > 0) begin
            free_count--;
            idx = free_stack[free_count];
            if (idx < DLA_ENTRIES) begin
              handle_table[idx] = handle;
              ans.letter = DLA_LETTER_W'(DLA_CODE_A + idx);
              ans.ok     = 1'b1;
              n_granted++;
            end
          end else begin
            n_exhausted++;
          end
        end
        OP_UNMOUNT: begin
          if (in_range && handle_table[idx] != '0) begin
            handle_table[idx] = '0;
            // push is dropped on a full stack
            if (free_count < DLA_ENTRIES) begin
              free_stack[free_count] = idx;
              free_count++;
            end
            ans.ok = 1'b1;
            n_released++;
          end else begin
            n_refused++;
          end
        end
        OP_LOOKUP: begin
          n_lookups++;
          if (in_range) begin
            ans.handle = handle_table[idx];
            ans.ok     = 1'b1;
          end
        end
        default: n_ignored++;
      endcase
      expected_answers.push_back(ans);
    endfunction

    function void report(string what, answer_t want, answer_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: letter exp %0d got %0d, handle exp %h got %h, ok exp %0d got %0d",
                 what, want.letter, got.letter, want.handle, got.handle, want.ok, got.ok);
    endfunction

    // Compare one result item with the oldest expected answer
    function void check_answer(logic [OUT_W-1:0] tdata);
      answer_t got, want;
      got.letter = tdata[DLA_LETTER_W-1:0];
      got.handle = tdata[DLA_LETTER_W +: DLA_HANDLE_BITS];
      got.ok     = tdata[DLA_LETTER_W + DLA_HANDLE_BITS];
      if (expected_answers.size() == 0) begin
        report("result with no request pending", '0, got);
        return;
      end
      want = expected_answers.pop_front();
      checked++;
      if (got !== want) report($sformatf("answer %0d", checked), want, got);
    endfunction

    // Code of a letter that currently holds a handle, if any
    function logic [DLA_CODE_W-1:0] pick_mounted();
      int unsigned live [$];
      for (int i = 0; i < DLA_ENTRIES; i++)
        if (handle_table[i] != '0) live.push_back(i);
      if (live.size() == 0) return DLA_CODE_A + DLA_CODE_W'($urandom_range(0, DLA_ENTRIES - 1));
      return DLA_CODE_A + DLA_CODE_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  alloc_scoreboard tracker = new();
  int unsigned     burst_left = 0;
  bit              hold_off   = 1'b0;
  bit              stall_done = 1'b0;
  int unsigned     idle_cycles = 0;

  drive_letter_allocator_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Offer one request, with a random gap when a burst runs out
  task automatic send_item(input logic [DLA_FUNC_W-1:0] func, input logic [DLA_CODE_W-1:0] code,
                           input logic [DLA_HANDLE_BITS-1:0] handle);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = hold_off ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tdata  <= IN_W'({handle, code, func});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(func, code, handle);
  endtask

  // Result side: check each taken item, then pick the next ready value
  initial begin
    int unsigned cyc, mode, stall_left;
    cyc = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_answer(m_tdata);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      // one long hold-off so the block fills up and backs up its input
      if (!stall_done && tracker.accepted >= STALL_AT_ITEM) begin
        stall_done = 1'b1;
        hold_off   = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) hold_off = 1'b0;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 9) < 7);
          default: m_tready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("** drive_letter_allocator_table: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [DLA_FUNC_W-1:0]      func;
    logic [DLA_CODE_W-1:0]      code;
    logic [DLA_HANDLE_BITS-1:0] handle;
    int unsigned                roll, zero_mounts;
    bit                         heavy_mount;
    zero_mounts = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lookups and unmounts on an empty table, in and out of range, and one unused op
    send_item(OP_LOOKUP, DLA_CODE_A, '0);
    send_item(OP_LOOKUP, 8'd0, '1);
    send_item(OP_LOOKUP, 8'd255, '0);
    send_item(OP_LOOKUP, DLA_CODE_A - 8'd1, '0);
    send_item(OP_LOOKUP, DLA_CODE_Z + 8'd1, '0);
    send_item(OP_UNMOUNT, DLA_CODE_A, '0);
    send_item(OP_UNMOUNT, 8'd0, '0);
    send_item(OP_UNMOUNT, 8'd255, '1);
    send_item(OP_UNMOUNT, DLA_CODE_Z + 8'd1, '0);
    send_item(OP_UNMOUNT, DLA_CODE_A - 8'd1, '0);
    send_item(OP_UNUSED, 8'd255, '1);
    // grants, a zero handle that strands its letter, release and regrant
    send_item(OP_MOUNT, 8'd0, '1);
    send_item(OP_LOOKUP, DLA_CODE_A, '0);
    send_item(OP_MOUNT, 8'd255, '0);
    send_item(OP_UNMOUNT, DLA_CODE_A + 8'd1, '0);
    send_item(OP_MOUNT, 8'd0, 32'd1);
    send_item(OP_UNMOUNT, DLA_CODE_A + 8'd2, '0);
    send_item(OP_MOUNT, 8'd0, 32'h8000_0000);
    send_item(OP_LOOKUP, DLA_CODE_Z, '0);
    send_item(OP_UNMOUNT, DLA_CODE_A, '0);
    send_item(OP_MOUNT, 8'd0, 32'h5a5a_5a5a);

    // random part: alternating fill-heavy and release-heavy stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      heavy_mount = ((n / 120) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (heavy_mount)
        func = (roll < 60) ? OP_MOUNT : (roll < 80) ? OP_UNMOUNT :
               (roll < 95) ? OP_LOOKUP : OP_UNUSED;
      else
        func = (roll < 15) ? OP_MOUNT : (roll < 75) ? OP_UNMOUNT :
               (roll < 95) ? OP_LOOKUP : OP_UNUSED;
      roll = $urandom_range(0, 99);
      if (func == OP_MOUNT || func == OP_UNUSED || roll >= 85)
        code = DLA_CODE_W'($urandom_range(0, 255));
      else if (roll < 75)
        code = tracker.pick_mounted();
      else
        code = DLA_CODE_A + DLA_CODE_W'($urandom_range(0, DLA_ENTRIES - 1));
      handle = $urandom;
      // a zero handle strands a letter for good, so only a couple
      if (func == OP_MOUNT && zero_mounts < 2 && $urandom_range(0, 199) == 0) begin
        handle = '0;
        zero_mounts++;
      end else if (func == OP_MOUNT && handle == '0) begin
        handle = 1;
      end
      send_item(func, code, handle);
    end
    s_tvalid <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d letters granted, %0d mounts on an empty stack, %0d released",
             tracker.accepted, tracker.n_granted, tracker.n_exhausted, tracker.n_released);
    $display("%0d unmounts rejected, %0d lookups, %0d unused ops, %0d answers checked",
             tracker.n_refused, tracker.n_lookups, tracker.n_ignored, tracker.checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("** drive_letter_allocator_table: PASSED **");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", tracker.mismatches, tracker.pending());
      $display("** drive_letter_allocator_table: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dla_pkg.sv
hdl/dla_free_stack.sv
hdl/drive_letter_allocator_table.sv
tb/drive_letter_allocator_table_test.sv
